// ===== src/tfp_pkg.sv =====
// shared types, offsets and a helper function for the tunnel frame parser
`timescale 1ns / 1ps

package tfp_pkg;

   // fixed header offsets from frame start
   localparam logic [15:0] POS_VERSION   = 16'd0;
   localparam logic [15:0] POS_COMMAND   = 16'd1;
   localparam logic [15:0] POS_LEN_HI    = 16'd2;
   localparam logic [15:0] POS_LEN_LO    = 16'd3;
   localparam logic [15:0] POS_SEQ_HI    = 16'd4;
   localparam logic [15:0] POS_SEQ_LO    = 16'd5;
   localparam logic [15:0] POS_HOST_LEN  = 16'd6;
   localparam logic [15:0] POS_HOST_BASE = 16'd7;
   // header length is this plus the host length
   localparam logic [16:0] HDR_FIXED     = 17'd17;
   localparam logic [16:0] HOST_BASE_EXT = 17'd7;

   // field offsets past the host bytes
   localparam logic [3:0] SUB_PORT_HI  = 4'd0;
   localparam logic [3:0] SUB_PORT_LO  = 4'd1;
   localparam logic [3:0] SUB_SESS_3   = 4'd2;
   localparam logic [3:0] SUB_SESS_2   = 4'd3;
   localparam logic [3:0] SUB_SESS_1   = 4'd4;
   localparam logic [3:0] SUB_SESS_0   = 4'd5;
   localparam logic [3:0] SUB_PLEN_HI  = 4'd6;
   localparam logic [3:0] SUB_PLEN_LO  = 4'd7;
   localparam logic [3:0] SUB_CSUM_HI  = 4'd8;
   localparam logic [3:0] SUB_CSUM_LO  = 4'd9;

   typedef enum logic [1:0] {
      CLASS_FIELD   = 2'd0,
      CLASS_HOST    = 2'd1,
      CLASS_PAYLOAD = 2'd2,
      CLASS_TRAIL   = 2'd3
   } byte_class_type;

   typedef struct packed {
      byte_class_type byte_class;
      logic [7:0]     byte_value;
      logic           packet_done;
      logic           checksum_ok;
      logic [7:0]     version;
      logic [7:0]     command;
      logic [15:0]    sequence_res;
      logic [15:0]    port;
      logic [31:0]    session;
      logic [15:0]    payload_length;
      logic [7:0]     host_length;
      logic           length_error;
   } result_type;

   // 16-bit ones' complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

// ===== src/tfp_parse.sv =====
// frame parse state, running checksum and per-byte result logic
`timescale 1ns / 1ps

module tfp_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           byte_in,
   output tfp_pkg::result_type  res
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] frame_len_ff, frame_len_in;
   logic [7:0]  host_len_ff, host_len_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  pending_ff, pending_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  command_ff, command_in;
   logic [15:0] sequence_ff, sequence_in;
   logic [15:0] port_ff, port_in;
   logic [31:0] session_ff, session_in;
   logic [15:0] plen_ff, plen_in;
   logic [15:0] csum_ff, csum_in;

   logic [7:0]  h_cur;
   logic [16:0] pos_ext;
   logic [16:0] host_end;
   logic [16:0] hdr_len;
   logic [16:0] sub_full;
   logic [3:0]  sub;
   logic [16:0] pay_off;
   logic [15:0] len_new;
   logic [15:0] w0;
   logic [15:0] w1;
   logic [7:0]  v;
   logic        is_csum;
   logic        lerr;
   logic [16:0] end_pos;
   logic        done;
   logic [15:0] final_sum;
   tfp_pkg::byte_class_type cls;

   // host length is visible on the same byte that carries it
   assign h_cur    = (pos_ff == tfp_pkg::POS_HOST_LEN) ? byte_in : host_len_ff;
   assign pos_ext  = {1'b0, pos_ff};
   assign host_end = {9'd0, h_cur} + tfp_pkg::HOST_BASE_EXT;
   assign hdr_len  = {9'd0, h_cur} + tfp_pkg::HDR_FIXED;
   assign sub_full = pos_ext - host_end;
   assign sub      = sub_full[3:0];
   assign pay_off  = pos_ext - hdr_len;
   assign len_new  = {frame_len_ff[15:8], byte_in};

   // first-word terms of the sum, trimmed to the total length
   always_comb begin
      if (len_new >= 16'd2) begin
         w0 = {version_ff, command_ff};
      end else if (len_new == 16'd1) begin
         w0 = {version_ff, 8'h00};
      end else begin
         w0 = 16'h0000;
      end
      if (len_new >= 16'd4) begin
         w1 = len_new;
      end else if (len_new == 16'd3) begin
         w1 = {len_new[15:8], 8'h00};
      end else begin
         w1 = 16'h0000;
      end
   end

   // field capture, byte classification and checksum update
   always_comb begin
      frame_len_in = frame_len_ff;
      host_len_in  = host_len_ff;
      sum_in       = sum_ff;
      pending_in   = pending_ff;
      version_in   = version_ff;
      command_in   = command_ff;
      sequence_in  = sequence_ff;
      port_in      = port_ff;
      session_in   = session_ff;
      plen_in      = plen_ff;
      csum_in      = csum_ff;
      cls          = tfp_pkg::CLASS_FIELD;
      is_csum      = 1'b0;
      v            = 8'h00;

      if (pos_ff < tfp_pkg::POS_HOST_BASE) begin
         if (pos_ff == tfp_pkg::POS_VERSION) begin
            version_in = byte_in;
         end else if (pos_ff == tfp_pkg::POS_COMMAND) begin
            command_in = byte_in;
         end else if (pos_ff == tfp_pkg::POS_LEN_HI) begin
            frame_len_in = {byte_in, 8'h00};
         end else if (pos_ff == tfp_pkg::POS_LEN_LO) begin
            frame_len_in = len_new;
            // sum is always zero this early in a frame
            sum_in = tfp_pkg::oc_add(w0, w1);
         end else if (pos_ff == tfp_pkg::POS_SEQ_HI) begin
            sequence_in = {byte_in, sequence_ff[7:0]};
         end else if (pos_ff == tfp_pkg::POS_SEQ_LO) begin
            sequence_in = {sequence_ff[15:8], byte_in};
         end else begin
            host_len_in = byte_in;
         end
      end else if (pos_ext < host_end) begin
         cls = tfp_pkg::CLASS_HOST;
      end else if (pos_ext < hdr_len) begin
         case (sub)
            tfp_pkg::SUB_PORT_HI: port_in = {byte_in, port_ff[7:0]};
            tfp_pkg::SUB_PORT_LO: port_in = {port_ff[15:8], byte_in};
            tfp_pkg::SUB_SESS_3:  session_in = {byte_in, session_ff[23:0]};
            tfp_pkg::SUB_SESS_2:  session_in = {session_ff[31:24], byte_in, session_ff[15:0]};
            tfp_pkg::SUB_SESS_1:  session_in = {session_ff[31:16], byte_in, session_ff[7:0]};
            tfp_pkg::SUB_SESS_0:  session_in = {session_ff[31:8], byte_in};
            tfp_pkg::SUB_PLEN_HI: plen_in = {byte_in, plen_ff[7:0]};
            tfp_pkg::SUB_PLEN_LO: plen_in = {plen_ff[15:8], byte_in};
            tfp_pkg::SUB_CSUM_HI: begin
               csum_in = {byte_in, csum_ff[7:0]};
               is_csum = 1'b1;
            end
            default: begin
               csum_in = {csum_ff[15:8], byte_in};
               is_csum = 1'b1;
            end
         endcase
      end else if (pay_off < {1'b0, plen_ff}) begin
         cls = tfp_pkg::CLASS_PAYLOAD;
      end else begin
         cls = tfp_pkg::CLASS_TRAIL;
      end

      // bytes past the length field go into the sum in high/low pairs
      if (pos_ff >= tfp_pkg::POS_SEQ_HI) begin
         v = (pos_ff < frame_len_ff && !is_csum) ? byte_in : 8'h00;
         if (!pos_ff[0]) begin
            pending_in = v;
         end else begin
            sum_in = tfp_pkg::oc_add(sum_ff, {pending_ff, v});
         end
      end
   end

   // frame end and verdict
   always_comb begin
      lerr      = {1'b0, frame_len_ff} < hdr_len;
      end_pos   = lerr ? (hdr_len - 17'd1) : ({1'b0, frame_len_ff} - 17'd1);
      done      = (pos_ff >= tfp_pkg::POS_HOST_LEN) && (pos_ext == end_pos);
      final_sum = pos_ff[0] ? sum_in : tfp_pkg::oc_add(sum_ff, {v, 8'h00});
      pos_in    = done ? 16'd0 : (pos_ff + 16'd1);
   end

   // result item for the byte at hand
   always_comb begin
      res                = '0;
      res.byte_class     = cls;
      res.byte_value     = byte_in;
      if (done) begin
         res.packet_done    = 1'b1;
         res.checksum_ok    = (~final_sum == csum_in);
         res.version        = version_in;
         res.command        = command_in;
         res.sequence_res   = sequence_in;
         res.port           = port_in;
         res.session        = session_in;
         res.payload_length = plen_in;
         res.host_length    = host_len_in;
         res.length_error   = lerr;
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         frame_len_ff <= '0;
         host_len_ff  <= '0;
         sum_ff       <= '0;
         pending_ff   <= '0;
         version_ff   <= '0;
         command_ff   <= '0;
         sequence_ff  <= '0;
         port_ff      <= '0;
         session_ff   <= '0;
         plen_ff      <= '0;
         csum_ff      <= '0;
      end else if (step) begin
         pos_ff       <= pos_in;
         frame_len_ff <= frame_len_in;
         host_len_ff  <= host_len_in;
         sum_ff       <= done ? 16'h0000 : sum_in;
         pending_ff   <= done ? 8'h00 : pending_in;
         version_ff   <= version_in;
         command_ff   <= command_in;
         sequence_ff  <= sequence_in;
         port_ff      <= port_in;
         session_ff   <= session_in;
         plen_ff      <= plen_in;
         csum_ff      <= csum_in;
      end
   end

   // a finished frame restarts position and sum
   a_restart: assert property (@(posedge clock) disable iff (reset)
      step && res.packet_done |=> pos_ff == 16'd0 && sum_ff == 16'h0000)
      else $error("frame end did not restart parse state");

   // position advances by one inside a frame
   a_advance: assert property (@(posedge clock) disable iff (reset)
      step && !res.packet_done |=> pos_ff == $past(pos_ff) + 16'd1)
      else $error("byte position skipped");

   // host bytes never overlap the fixed leading fields
   a_host_pos: assert property (@(posedge clock) disable iff (reset)
      step && res.byte_class == tfp_pkg::CLASS_HOST |-> pos_ff >= tfp_pkg::POS_HOST_BASE)
      else $error("host byte inside fixed header");

   // a length error is only reported on a frame end
   a_lerr_done: assert property (@(posedge clock) disable iff (reset)
      res.length_error |-> res.packet_done)
      else $error("length error without frame end");

endmodule

// ===== src/tunnel_frame_parse_checksum_verify.sv =====
// top level: request register, frame parser and result register
`timescale 1ns / 1ps

// Tunnel frame parser with ones' complement checksum check. Takes one byte of a
// stream of back-to-back frames per request and gives one result per byte: its
// class and value, and on a frame's last byte the header fields, the checksum
// verdict and the length error flag. Throughput is one byte per clock while
// results are taken; a byte goes through the request register, then the result
// register. The rate is set by the per-byte field capture and one 16-bit
// end-around-carry add, both done in the single stage between the two
// registers. Backpressure on the result side stalls the request side only
// once both registers hold a byte.
module tunnel_frame_parse_checksum_verify (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_byte_class,
   output logic [7:0]  rsp_byte_value,
   output logic        rsp_packet_done,
   output logic        rsp_checksum_ok,
   output logic [7:0]  rsp_version,
   output logic [7:0]  rsp_command,
   output logic [15:0] rsp_sequence_res,
   output logic [15:0] rsp_port,
   output logic [31:0] rsp_session,
   output logic [15:0] rsp_payload_length,
   output logic [7:0]  rsp_host_length,
   output logic        rsp_length_error
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                out_valid_ff;
   tfp_pkg::result_type out_res_ff;
   tfp_pkg::result_type parse_res;
   logic                advance;

   // move the held request into the result register when it is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   tfp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .byte_in (in_byte_ff),
      .res     (parse_res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_res_ff <= parse_res;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_byte_class     = out_res_ff.byte_class;
   assign rsp_byte_value     = out_res_ff.byte_value;
   assign rsp_packet_done    = out_res_ff.packet_done;
   assign rsp_checksum_ok    = out_res_ff.checksum_ok;
   assign rsp_version        = out_res_ff.version;
   assign rsp_command        = out_res_ff.command;
   assign rsp_sequence_res   = out_res_ff.sequence_res;
   assign rsp_port           = out_res_ff.port;
   assign rsp_session        = out_res_ff.session;
   assign rsp_payload_length = out_res_ff.payload_length;
   assign rsp_host_length    = out_res_ff.host_length;
   assign rsp_length_error   = out_res_ff.length_error;

   // requests stall only when both stages are full and the result is held
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("request stalled with a free stage");

   // a held request moves on whenever the result side is taking
   a_drain: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_ready |=> out_valid_ff)
      else $error("held request not moved to result register");

   // the result register is never left holding a taken result with nothing new
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_ready && !in_valid_ff |=> !out_valid_ff)
      else $error("result repeated after it was taken");

endmodule
